// ===== hdl/hdr_latency_histogram_unit_assert.svh =====
// Assertion macros shared by the histogram modules.
`ifndef HDR_LATENCY_HISTOGRAM_UNIT_ASSERT_SVH
`define HDR_LATENCY_HISTOGRAM_UNIT_ASSERT_SVH

// An implication checked on every clock edge outside reset.
`define HLH_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// An implication whose consequent is checked in the next cycle.
`define HLH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/hdrh_pkg.sv =====
package hdrh_pkg;

    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] value;
        logic [13:0] percentile;
    } hdrh_in_t;

    typedef struct packed {
        logic [63:0] quantile_value;
        logic [63:0] sample_total;
        logic [63:0] smallest_seen;
        logic [63:0] largest_seen;
        logic [63:0] running_sum;
    } hdrh_out_t;

    localparam logic [1:0] FUNC_RECORD   = 2'd0;
    localparam logic [1:0] FUNC_QUANTILE = 2'd1;
    localparam logic [1:0] FUNC_CLEAR    = 2'd2;

    localparam logic [63:0] FULL_PERCENT = 64'd10000;
    localparam logic [63:0] RESET_LIMIT  = 64'd4294967295;

    // Command passed from the classifying front to the store back end.
    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] value;
        logic [13:0] percentile;
        logic [6:0]  shift;
    } hdrh_cmd_t;

    function automatic logic [6:0] bit_len(input logic [63:0] v);
        logic [6:0] n;
        n = 7'd0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                n = 7'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

// ===== hdl/hdrh_front.sv =====
module hdrh_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  hdrh_pkg::hdrh_in_t in_data,
    output logic              q_valid,
    input  logic              q_ready,
    output hdrh_pkg::hdrh_cmd_t q_data
);
    import hdrh_pkg::*;

    // Two-entry queue; the front computes the value's bit length on entry.
    hdrh_cmd_t  mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_data   = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= '{func: in_data.func, value: in_data.value,
                                 percentile: in_data.percentile,
                                 shift: bit_len(in_data.value)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= !wp_reg;
            end
            if (pop)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    `include "hdr_latency_histogram_unit_assert.svh"
    `HLH_ASSERT_IMP(a_cnt_range, 1'b1, cnt_reg <= 2'd2)
    `HLH_ASSERT_NEXT(a_full_next, push && !pop && cnt_reg == 2'd1, cnt_reg == 2'd2)
    `HLH_ASSERT_NEXT(a_empty_next, pop && !push && cnt_reg == 2'd1, cnt_reg == 2'd0)
endmodule

// ===== hdl/hdrh_back.sv =====
module hdrh_back #(
    parameter int HALF_MAG      = 7,
    parameter int MAX_BUCKETS   = 16,
    parameter int COUNTER_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_ready,
    input  hdrh_pkg::hdrh_cmd_t q_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [63:0]         cfg_data,
    output logic                out_valid,
    input  logic                out_ready,
    output hdrh_pkg::hdrh_out_t out_data
);
    import hdrh_pkg::*;

    localparam int DEPTH = (2 + MAX_BUCKETS) << HALF_MAG;
    localparam int AW    = $clog2(DEPTH);
    localparam int HALF  = 1 << HALF_MAG;
    localparam logic [COUNTER_WIDTH-1:0] CMAX = '1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_REC_RD, S_REC_LAT, S_REC_WR, S_QUANT, S_RANK,
        S_SCAN_RD, S_SCAN, S_CHECK, S_FLOOR, S_OUT
    } state_t;

    state_t state_reg;

    logic [COUNTER_WIDTH-1:0] mem [DEPTH];
    logic [COUNTER_WIDTH-1:0] rdata_reg;
    logic [AW-1:0]            addr_reg;
    logic [AW:0]              slots_reg;
    logic                     fits_reg;
    logic [63:0]              limit_reg;
    logic [63:0]              total_reg, min_reg, max_reg, sum_reg;
    logic [63:0]              qv_reg;
    hdrh_cmd_t                cmd_reg;
    logic [63:0]              run_reg;
    logic [77:0]              target_reg;
    logic [45:0]              prod_a_reg;
    logic [45:0]              prod_b_reg;
    hdrh_out_t                out_reg;
    logic                     out_valid_reg;

    logic [6:0]  cfg_len;
    logic [6:0]  cfg_bk;
    logic [AW:0] slot_idx;
    logic [6:0]  rb;
    logic [63:0] run_sum;
    logic [64:0] run_add;
    logic [77:0] run_x;
    logic [AW-1:0] fl_b;
    logic [63:0] fl_sub;

    assign cfg_ready = (state_reg == S_IDLE) && !q_valid && !out_valid_reg;
    assign q_ready   = (state_reg == S_IDLE) && !out_valid_reg && !cfg_valid;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        cfg_len = bit_len(cfg_data);
        cfg_bk  = (cfg_len > 7'(HALF_MAG + 1)) ? cfg_len - 7'(HALF_MAG + 1) : 7'd0;
        if (cfg_bk > 7'(MAX_BUCKETS))
        begin
            cfg_bk = 7'(MAX_BUCKETS);
        end
    end

    always_comb
    begin
        rb = cmd_reg.shift - 7'(HALF_MAG + 1);
        if (cmd_reg.value < 64'(HALF))
        begin
            slot_idx = (AW + 1)'(cmd_reg.value);
        end
        else if (fits_reg && cmd_reg.value >= limit_reg)
        begin
            slot_idx = slots_reg - 1'b1;
        end
        else
        begin
            slot_idx = (AW + 1)'((64'(rb) << HALF_MAG) + (cmd_reg.value >> rb));
        end
    end

    assign run_add = {1'b0, run_reg} + 65'(rdata_reg);
    assign run_sum = run_add[64] ? '1 : run_add[63:0];
    assign run_x   = 78'(run_reg) * 78'(FULL_PERCENT);
    assign fl_b    = (addr_reg >> HALF_MAG) - 1'b1;
    assign fl_sub  = 64'(addr_reg & AW'(HALF - 1)) + 64'(HALF);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
        begin
            mem[addr_reg] <= '0;
        end
        else if (state_reg == S_REC_WR && rdata_reg != CMAX && slot_idx < (AW + 1)'(DEPTH))
        begin
            mem[addr_reg] <= rdata_reg + COUNTER_WIDTH'(1);
        end
        rdata_reg <= mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            addr_reg      <= '0;
            fits_reg      <= 1'b1;
            total_reg     <= '0;
            min_reg       <= '1;
            max_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
            cmd_reg       <= '0;
            qv_reg        <= '0;
            run_reg       <= '0;
            target_reg    <= '0;
            prod_a_reg    <= '0;
            prod_b_reg    <= '0;
            out_reg       <= '0;
            slots_reg     <= (AW + 1)'((2 + ((MAX_BUCKETS < 32 - HALF_MAG - 1) ?
                             MAX_BUCKETS : 32 - HALF_MAG - 1)) << HALF_MAG);
            limit_reg     <= 64'(2 * HALF) << ((MAX_BUCKETS < 32 - HALF_MAG - 1) ?
                             MAX_BUCKETS : 32 - HALF_MAG - 1);
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    total_reg <= '0;
                    min_reg   <= '1;
                    max_reg   <= '0;
                    sum_reg   <= '0;
                    if (addr_reg == AW'(DEPTH - 1))
                    begin
                        addr_reg <= '0;
                        state_reg <= (cmd_reg.func == FUNC_CLEAR) ? S_OUT : S_IDLE;
                    end
                    else
                    begin
                        addr_reg <= addr_reg + 1'b1;
                    end
                end
                S_IDLE:
                begin
                    qv_reg <= '0;
                    if (cfg_valid && cfg_ready)
                    begin
                        slots_reg   <= (AW + 1)'((64'(2) + 64'(cfg_bk)) << HALF_MAG);
                        fits_reg    <= (7'(HALF_MAG + 1) + cfg_bk) < 7'd64;
                        limit_reg   <= 64'(2 * HALF) << cfg_bk;
                        addr_reg    <= '0;
                        cmd_reg     <= '0;
                        state_reg   <= S_CLEAR;
                    end
                    else if (q_valid && q_ready)
                    begin
                        cmd_reg <= q_data;
                        unique case (q_data.func)
                            FUNC_RECORD:   state_reg <= S_REC_RD;
                            FUNC_QUANTILE: state_reg <= S_QUANT;
                            FUNC_CLEAR:
                            begin
                                addr_reg  <= '0;
                                state_reg <= S_CLEAR;
                            end
                            default:       state_reg <= S_OUT;
                        endcase
                    end
                end
                S_REC_RD:
                begin
                    addr_reg  <= AW'(slot_idx);
                    state_reg <= S_REC_LAT;
                end
                S_REC_LAT:
                begin
                    state_reg <= S_REC_WR;
                end
                S_REC_WR:
                begin
                    // Read data arrives now; the write happens this cycle.
                    total_reg <= total_reg + 64'd1;
                    sum_reg   <= sum_reg + cmd_reg.value;
                    if (cmd_reg.value < min_reg)
                    begin
                        min_reg <= cmd_reg.value;
                    end
                    if (cmd_reg.value > max_reg)
                    begin
                        max_reg <= cmd_reg.value;
                    end
                    state_reg <= S_OUT;
                end
                S_QUANT:
                begin
                    if (total_reg == '0 || cmd_reg.percentile == '0)
                    begin
                        qv_reg    <= '0;
                        state_reg <= S_OUT;
                    end
                    else if (64'(cmd_reg.percentile) >= FULL_PERCENT)
                    begin
                        qv_reg    <= max_reg;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        prod_a_reg <= 46'(cmd_reg.percentile) * 46'(total_reg[63:32]);
                        prod_b_reg <= 46'(cmd_reg.percentile) * 46'(total_reg[31:0]);
                        state_reg  <= S_RANK;
                    end
                end
                S_RANK:
                begin
                    // A slot is reached once the running count times 10000 covers
                    // percentile times total, which is the rounded-up rank.
                    target_reg <= {prod_a_reg, 32'd0} + 78'(prod_b_reg);
                    run_reg    <= '0;
                    addr_reg   <= '0;
                    state_reg  <= S_SCAN_RD;
                end
                S_SCAN_RD:
                begin
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    run_reg   <= run_sum;
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (run_x >= target_reg)
                    begin
                        state_reg <= S_FLOOR;
                    end
                    else if ((AW + 1)'(addr_reg) + 1'b1 >= slots_reg ||
                             (AW + 1)'(addr_reg) + 1'b1 >= (AW + 1)'(DEPTH))
                    begin
                        qv_reg    <= max_reg;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        addr_reg  <= addr_reg + 1'b1;
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_FLOOR:
                begin
                    if (64'(addr_reg) < 64'(2 * HALF))
                    begin
                        qv_reg <= 64'(addr_reg);
                    end
                    else
                    begin
                        qv_reg <= fl_sub << fl_b;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_reg <= '{quantile_value: qv_reg, sample_total: total_reg,
                                     smallest_seen: min_reg, largest_seen: max_reg,
                                     running_sum: sum_reg};
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `include "hdr_latency_histogram_unit_assert.svh"
    `HLH_ASSERT_IMP(a_cfg_quiet, cfg_valid && cfg_ready, !out_valid_reg)
    `HLH_ASSERT_NEXT(a_rec_out, state_reg == S_REC_WR, state_reg == S_OUT)
    `HLH_ASSERT_IMP(a_minmax, total_reg != '0 && state_reg == S_IDLE, min_reg <= max_reg)
endmodule

// ===== hdl/hdr_latency_histogram_unit.sv =====
// Channel   Direction  Payload
// in        input      hdrh_in_t: func, value, percentile
// out       output     hdrh_out_t: quantile and statistics
// cfg       input      largest_tracked_value, 64 bits
// A record item passes from its input handshake to the earliest result handshake through
// the queue, slot lookup, counter read, counter write and result register.
// A quantile item first forms the rank product, then reads, sums and checks each slot scanned.
// Reset, a clear item and each register write clear the counter store, one entry a
// cycle, 2304 entries at the default size.
// A two-entry queue lets the input side take up to two items while the back end stalls.
module hdr_latency_histogram_unit #(
    parameter int HALF_MAG      = 7,
    parameter int MAX_BUCKETS   = 16,
    parameter int COUNTER_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  hdrh_pkg::hdrh_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output hdrh_pkg::hdrh_out_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [63:0]         cfg_data
);
    import hdrh_pkg::*;

    logic      q_valid, q_ready;
    hdrh_cmd_t q_data;

    hdrh_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_data(in_data), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    hdrh_back #(
        .HALF_MAG(HALF_MAG), .MAX_BUCKETS(MAX_BUCKETS), .COUNTER_WIDTH(COUNTER_WIDTH)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );
endmodule

// ===== dv/tb_hdr_latency_histogram_unit.sv =====
module tb_hdr_latency_histogram_unit;
    import hdrh_pkg::*;

    localparam int HALF_MAG      = 7;
    localparam int MAX_BUCKETS   = 16;
    localparam int COUNTER_WIDTH = 32;
    localparam int HALF_COUNT    = 1 << HALF_MAG;
    localparam int STORE_DEPTH   = (2 + MAX_BUCKETS) << HALF_MAG;
    localparam logic [63:0] COUNTER_MAX = {64{1'b1}} >> (64 - COUNTER_WIDTH);
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    hdrh_in_t    in_data;
    logic        out_valid;
    logic        out_ready;
    hdrh_out_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [63:0] cfg_data;

    hdr_latency_histogram_unit #(
        .HALF_MAG(HALF_MAG),
        .MAX_BUCKETS(MAX_BUCKETS),
        .COUNTER_WIDTH(COUNTER_WIDTH)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    logic [63:0] hist_counts [STORE_DEPTH];
    logic [63:0] hist_total;
    logic [63:0] hist_min;
    logic [63:0] hist_max;
    logic [63:0] hist_sum;
    int          slots_used;
    logic [63:0] range_limit;
    bit          range_fits;
    hdrh_out_t   pending_results [$];
    int          error_count;
    logic [63:0] recorded_values [$];

    function automatic int bit_length(input logic [63:0] v);
        int n;
        n = 0;
        for (int i = 0; i < 64; i++)
        begin
            if (v[i])
            begin
                n = i + 1;
            end
        end
        return n;
    endfunction

    function automatic void wipe_histogram();
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            hist_counts[i] = 64'd0;
        end
        hist_total = 64'd0;
        hist_min   = {64{1'b1}};
        hist_max   = 64'd0;
        hist_sum   = 64'd0;
    endfunction

    function automatic void apply_layout(input logic [63:0] largest);
        int len;
        int buckets;
        len = bit_length(largest);
        buckets = 0;
        if (len > HALF_MAG + 1)
        begin
            buckets = len - HALF_MAG - 1;
        end
        if (buckets > MAX_BUCKETS)
        begin
            buckets = MAX_BUCKETS;
        end
        slots_used  = (2 + buckets) << HALF_MAG;
        range_fits  = (HALF_MAG + 1 + buckets) < 64;
        range_limit = range_fits ? (64'd2 * HALF_COUNT) << buckets : {64{1'b1}};
        wipe_histogram();
    endfunction

    function automatic int slot_index(input logic [63:0] v);
        int b;
        if (v < HALF_COUNT)
        begin
            return int'(v);
        end
        if (range_fits && v >= range_limit)
        begin
            return slots_used - 1;
        end
        b = bit_length(v) - HALF_MAG - 1;
        return (b << HALF_MAG) + int'(v >> b);
    endfunction

    function automatic logic [63:0] slot_lower_bound(input int idx);
        int b;
        logic [63:0] sub;
        if (idx < 2 * HALF_COUNT)
        begin
            return 64'(idx);
        end
        b = (idx >> HALF_MAG) - 1;
        sub = 64'((idx & (HALF_COUNT - 1)) + HALF_COUNT);
        return sub << b;
    endfunction

    function automatic logic [63:0] percentile_value(input logic [13:0] pct);
        logic [127:0] prod;
        logic [63:0]  rank;
        logic [63:0]  running;
        if (hist_total == 0 || pct == 0)
        begin
            return 64'd0;
        end
        if (64'(pct) >= FULL_PERCENT)
        begin
            return hist_max;
        end
        prod = 128'(pct) * 128'(hist_total);
        rank = 64'((prod + 128'(FULL_PERCENT) - 128'd1) / 128'(FULL_PERCENT));
        if (rank < 64'd1)
        begin
            rank = 64'd1;
        end
        if (rank > hist_total)
        begin
            rank = hist_total;
        end
        running = 64'd0;
        for (int i = 0; i < slots_used && i < STORE_DEPTH; i++)
        begin
            running = (running > ~hist_counts[i]) ? {64{1'b1}} : running + hist_counts[i];
            if (running >= rank)
            begin
                return slot_lower_bound(i);
            end
        end
        return hist_max;
    endfunction

    function automatic hdrh_out_t histogram_step(input hdrh_in_t item);
        hdrh_out_t res;
        int s;
        res.quantile_value = 64'd0;
        case (item.func)
            FUNC_RECORD:
            begin
                s = slot_index(item.value);
                if (s < STORE_DEPTH && hist_counts[s] < COUNTER_MAX)
                begin
                    hist_counts[s]++;
                end
                hist_total++;
                hist_sum += item.value;
                if (item.value < hist_min)
                begin
                    hist_min = item.value;
                end
                if (item.value > hist_max)
                begin
                    hist_max = item.value;
                end
            end
            FUNC_QUANTILE:
            begin
                res.quantile_value = percentile_value(item.percentile);
            end
            FUNC_CLEAR:
            begin
                wipe_histogram();
            end
            default:
            begin
            end
        endcase
        res.sample_total  = hist_total;
        res.smallest_seen = hist_min;
        res.largest_seen  = hist_max;
        res.running_sum   = hist_sum;
        return res;
    endfunction

    task automatic send_item(input hdrh_in_t item);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        pending_results.push_back(histogram_step(item));
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    task automatic write_limit(input logic [63:0] largest);
        drain_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= largest;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        apply_layout(largest);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic hdrh_in_t make_item(input logic [1:0] f, input logic [63:0] v,
                                           input logic [13:0] p);
        hdrh_in_t item;
        item.func       = f;
        item.value      = v;
        item.percentile = p;
        return item;
    endfunction

    function automatic logic [63:0] random_value();
        int sh;
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        case ($urandom_range(0, 4))
            0: return 64'($urandom_range(0, 255));
            1: return v;
            2: return recorded_values.size() != 0 ?
                   recorded_values[$urandom_range(0, recorded_values.size() - 1)] : v;
            default:
            begin
                sh = $urandom_range(0, 63);
                return v >> sh;
            end
        endcase
    endfunction

    task automatic test_directed();
        send_item(make_item(FUNC_QUANTILE, 64'd0, 14'd5000));
        send_item(make_item(FUNC_RECORD, 64'd0, 14'h3fff));
        send_item(make_item(FUNC_RECORD, 64'd127, 14'd0));
        send_item(make_item(FUNC_RECORD, 64'd128, 14'd0));
        send_item(make_item(FUNC_RECORD, 64'd255, 14'd0));
        send_item(make_item(FUNC_RECORD, 64'd256, 14'd0));
        send_item(make_item(FUNC_RECORD, 64'hffff_ffff, 14'd0));
        send_item(make_item(FUNC_RECORD, 64'h1_0000_0000, 14'd0));
        send_item(make_item(FUNC_RECORD, {64{1'b1}}, 14'd0));
        send_item(make_item(FUNC_QUANTILE, {64{1'b1}}, 14'd0));
        send_item(make_item(FUNC_QUANTILE, 64'd0, 14'd1));
        send_item(make_item(FUNC_QUANTILE, 64'd0, 14'd5000));
        send_item(make_item(FUNC_QUANTILE, 64'd0, 14'd9999));
        send_item(make_item(FUNC_QUANTILE, 64'd0, 14'd10000));
        send_item(make_item(FUNC_QUANTILE, 64'd0, 14'h3fff));
        send_item(make_item(FUNC_UNUSED, {64{1'b1}}, 14'h3fff));
        send_item(make_item(FUNC_CLEAR, 64'd5, 14'd7));
        send_item(make_item(FUNC_QUANTILE, 64'd0, 14'd10000));
        send_item(make_item(FUNC_RECORD, {64{1'b1}}, 14'd0));
        send_item(make_item(FUNC_RECORD, {64{1'b1}}, 14'd0));
        send_item(make_item(FUNC_QUANTILE, 64'd0, 14'd5000));
    endtask

    task automatic test_random(input int count);
        int roll;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 80)
            begin
                send_item(make_item(FUNC_RECORD, random_value(), 14'($urandom())));
                recorded_values.push_back(in_data.value);
                if (recorded_values.size() > 64)
                begin
                    void'(recorded_values.pop_front());
                end
            end
            else if (roll < 95)
            begin
                send_item(make_item(FUNC_QUANTILE, {$urandom(), $urandom()},
                    $urandom_range(0, 3) == 0 ? 14'($urandom()) : 14'($urandom_range(0, 10000))));
            end
            else if (roll < 97)
            begin
                send_item(make_item(FUNC_CLEAR, {$urandom(), $urandom()}, 14'($urandom())));
            end
            else
            begin
                send_item(make_item(FUNC_UNUSED, {$urandom(), $urandom()}, 14'($urandom())));
            end
        end
    endtask

    task automatic test_layouts();
        logic [63:0] limits [7];
        limits = '{64'd0, 64'd1, 64'd255, 64'd256, 64'h1_ffff, {64{1'b1}}, 64'h0000_0fff_ffff_ffff};
        foreach (limits[i])
        begin
            write_limit(limits[i]);
            test_directed();
            test_random(200);
        end
    endtask

    always @(posedge clk)
    begin
        hdrh_out_t exp_res;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, out_data);
                error_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (exp_res.quantile_value !== out_data.quantile_value)
                begin
                    $display("%0t: quantile_value expected %h actual %h", $time,
                        exp_res.quantile_value, out_data.quantile_value);
                    error_count++;
                end
                if (exp_res.sample_total !== out_data.sample_total)
                begin
                    $display("%0t: sample_total expected %h actual %h", $time,
                        exp_res.sample_total, out_data.sample_total);
                    error_count++;
                end
                if (exp_res.smallest_seen !== out_data.smallest_seen)
                begin
                    $display("%0t: smallest_seen expected %h actual %h", $time,
                        exp_res.smallest_seen, out_data.smallest_seen);
                    error_count++;
                end
                if (exp_res.largest_seen !== out_data.largest_seen)
                begin
                    $display("%0t: largest_seen expected %h actual %h", $time,
                        exp_res.largest_seen, out_data.largest_seen);
                    error_count++;
                end
                if (exp_res.running_sum !== out_data.running_sum)
                begin
                    $display("%0t: running_sum expected %h actual %h", $time,
                        exp_res.running_sum, out_data.running_sum);
                    error_count++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 3) == 0) ? 1'b0 : 1'b1;
        end
    end

    initial
    begin
        #200000000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        error_count = 0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_data  = 64'd0;
        apply_layout(RESET_LIMIT);
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random(600);
        test_layouts();
        drain_results();
        if (error_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
